// ----- rtl/jbpi_pkg.sv -----
// constants, state codes and register indexes shared by the bucket pose integrator
// no dependencies
package jbpi_pkg;

  localparam int FRAC_BITS = 12;

  localparam logic signed [31:0] ONE       = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] FWD_MIN   = -ONE;
  localparam logic signed [31:0] FWD_MAX   = 4 * ONE;
  localparam logic signed [31:0] HGT_MIN   = 32'sd0;
  localparam logic signed [31:0] HGT_MAX   = (7 * ONE) / 2;
  localparam logic signed [31:0] BOOM_BASE = (3 * ONE) / 2;
  localparam logic signed [31:0] TILT_LIM  = (157 * ONE + 50) / 100;
  localparam logic signed [31:0] PI_Q      = 32'((64'sd314159265 * 64'(ONE) + 64'sd50000000)
                                                 / 64'sd100000000);
  localparam logic signed [31:0] YAW_LIM   = ONE / 2;

  localparam int DIV_W  = 26;  // quotient bits of the deadband rescale
  localparam int ACC_W  = 53;  // stick * rate * time step
  localparam int SQ_W   = 30;  // sum of squares

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AX_INIT,
    ST_AX_DIV,
    ST_AX_MUL1,
    ST_AX_MUL2,
    ST_AX_UPD,
    ST_SQ1,
    ST_SQ2,
    ST_SQRT,
    ST_YAW,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    REG_DEADBAND,
    REG_SPEED_X,
    REG_SPEED_Z,
    REG_RATE_HEADING,
    REG_RATE_TILT,
    REG_HEADING_GAIN,
    REG_REACH_MIN,
    REG_REACH_MAX
  } reg_idx_t;

endpackage

// ----- rtl/jbpi_isqrt.sv -----
// bit-pair serial integer square root, one result bit per cycle
// depends on jbpi_pkg
module jbpi_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [jbpi_pkg::SQ_W-1:0] value,
  output logic                     done,
  output logic [14:0]              root
);
  import jbpi_pkg::*;

  logic [SQ_W-1:0] rem, res, bitv;
  logic            busy;
  logic [SQ_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[14:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= value;
        res  <= '0;
        bitv <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == SQ_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/joystick_bucket_pose_integrator_core.sv -----
// top level of the bucket pose integrator: control sequencer, serial divider and multiplier
// depends on jbpi_pkg and jbpi_isqrt
//
// One input word per control tick. The four stick axes are handled one after another:
// each passes a set-up state, is rescaled through its deadband by a one-bit-per-cycle
// restoring divider, then multiplied by its rate and by the time step on a shift-add
// multiplier one bit per cycle, and added into the stored pose with clamp (the heading
// wraps, then clamps). The boom extension then takes two serial squarings and a square
// root with its done flag, and the yaw command one more serial multiply and a final state
// that loads the output register once it is free. A new word is taken only with the
// sequencer in idle. The result sits in an output register, so the next word is taken as
// soon as the sequencer is back in idle even if the previous result has not been collected.
module joystick_bucket_pose_integrator_core (
  input  logic        clk,
  input  logic        rst,
  // stick_fwd[13:0], stick_height[27:14], stick_heading[41:28], stick_tilt[55:42],
  // time_step[68:56], base_heading[83:69], zero fill above
  input  logic [87:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // boom_target[14:0], tilt_target[28:15], heading_target[44:29], yaw_rate_cmd[57:45],
  // zero fill above
  output logic [63:0] m_tdata,
  output logic        m_tuser,   // reach_limited
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import jbpi_pkg::*;

  // configuration registers
  logic [11:0] deadband;
  logic [13:0] max_speed_x, max_speed_z, max_rate_heading, max_rate_tilt, heading_gain;
  logic [14:0] reach_min, reach_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband         <= 12'd205;
      max_speed_x      <= 14'd2048;
      max_speed_z      <= 14'd1229;
      max_rate_heading <= 14'd1229;
      max_rate_tilt    <= 14'd2048;
      heading_gain     <= 14'd2048;
      reach_min        <= 15'd2048;
      reach_max        <= 15'd12288;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEADBAND:     deadband         <= cfg_data[11:0];
        REG_SPEED_X:      max_speed_x      <= cfg_data[13:0];
        REG_SPEED_Z:      max_speed_z      <= cfg_data[13:0];
        REG_RATE_HEADING: max_rate_heading <= cfg_data[13:0];
        REG_RATE_TILT:    max_rate_tilt    <= cfg_data[13:0];
        REG_HEADING_GAIN: heading_gain     <= cfg_data[13:0];
        REG_REACH_MIN:    reach_min        <= cfg_data;
        REG_REACH_MAX:    reach_max        <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  state_t state, state_next;
  logic [1:0]  axis, axis_next;
  logic [4:0]  cnt, cnt_next;
  logic [DIV_W-1:0] dvd, dvd_next;      // dividend in, quotient out
  logic [12:0] dsr, dsr_next;           // one minus deadband
  logic [12:0] rem, rem_next;
  logic        neg, neg_next;
  logic [ACC_W-1:0] mcand, mcand_next, acc, acc_next, acc_sum;
  logic [13:0] mplier, mplier_next;

  logic signed [13:0] stick [4];
  logic [12:0]        dt_r;
  logic signed [14:0] chassis_r;

  logic signed [15:0] pose_fwd, pose_height, pose_heading, pose_tilt;
  logic signed [15:0] pose_fwd_next, pose_height_next, pose_heading_next, pose_tilt_next;

  logic [63:0] m_tdata_next;
  logic        m_tuser_next, m_tvalid_next;

  // square root unit
  logic        sq_start, sq_done;
  logic [14:0] sq_root;

  jbpi_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (acc_sum[SQ_W-1:0]),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign s_tready = (state == ST_IDLE);

  // shared combinational pieces
  logic signed [13:0] s_sel;
  logic [13:0]        a_mag;
  logic               db_zero;
  logic [13:0]        trial;
  logic               ge;
  logic [13:0]        rate_sel;
  logic signed [31:0] delta, vsum, vwrap, vclamp;
  logic signed [31:0] dx, dz;
  logic [13:0]        dx_mag, dz_mag;
  logic signed [15:0] yaw_e;
  logic [13:0]        e_mag;
  logic [15:0]        ymag;
  logic [12:0]        yaw_v;
  logic [14:0]        ext_lim, ext_fin;
  logic               limited;
  logic [15:0]        hdg_tgt;

  always_comb begin
    s_sel   = stick[axis];
    a_mag   = s_sel[13] ? 14'(-s_sel) : 14'(s_sel);
    db_zero = (deadband >= 12'(ONE >>> 1) * 2) || (a_mag < {2'b0, deadband});

    trial   = {rem, dvd[DIV_W-1]};
    ge      = trial >= {1'b0, dsr};

    acc_sum = acc + (mplier[0] ? mcand : '0);

    case (axis)
      2'd0:    rate_sel = max_speed_x;
      2'd1:    rate_sel = max_speed_z;
      2'd2:    rate_sel = max_rate_heading;
      default: rate_sel = max_rate_tilt;
    endcase

    // delta from the product, truncated toward zero
    delta = neg ? -32'(acc[ACC_W-1:2*FRAC_BITS]) : 32'(acc[ACC_W-1:2*FRAC_BITS]);
    case (axis)
      2'd0:    vsum = 32'(pose_fwd) + delta;
      2'd1:    vsum = 32'(pose_height) + delta;
      2'd2:    vsum = 32'(pose_heading) + delta;
      default: vsum = 32'(pose_tilt) + delta;
    endcase
    // heading wraps once, then clamps
    if (vsum >= PI_Q)       vwrap = vsum - 2 * PI_Q;
    else if (vsum < -PI_Q)  vwrap = vsum + 2 * PI_Q;
    else                    vwrap = vsum;
    if (vwrap > PI_Q)       vclamp = PI_Q;
    else if (vwrap < -PI_Q) vclamp = -PI_Q;
    else                    vclamp = vwrap;

    dx     = 32'(pose_fwd) - BOOM_BASE;
    dz     = 32'(pose_height);
    dx_mag = dx[31] ? 14'(-dx) : 14'(dx);
    dz_mag = 14'(dz);

    // yaw error: heading wrapped once more, so pi reads as minus pi
    yaw_e  = (32'(pose_heading) == PI_Q) ? 16'(-PI_Q) : pose_heading;
    e_mag  = yaw_e[15] ? 14'(-yaw_e) : 14'(yaw_e);
    ymag   = acc[FRAC_BITS +: 16];
    if (32'(ymag) > YAW_LIM) ymag = 16'(YAW_LIM);
    yaw_v  = yaw_e[15] ? 13'(-ymag) : 13'(ymag);

    limited = sq_root > reach_max;
    ext_lim = limited ? reach_max : sq_root;
    ext_fin = (ext_lim < reach_min) ? reach_min : ext_lim;

    hdg_tgt = 16'(chassis_r) + 16'(pose_heading);
  end

  // sequencer
  always_comb begin
    state_next        = state;
    axis_next         = axis;
    cnt_next          = cnt;
    dvd_next          = dvd;
    dsr_next          = dsr;
    rem_next          = rem;
    neg_next          = neg;
    mcand_next        = mcand;
    mplier_next       = mplier;
    acc_next          = acc;
    pose_fwd_next     = pose_fwd;
    pose_height_next  = pose_height;
    pose_heading_next = pose_heading;
    pose_tilt_next    = pose_tilt;
    m_tdata_next      = m_tdata;
    m_tuser_next      = m_tuser;
    m_tvalid_next     = m_tvalid && !m_tready;
    sq_start          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          axis_next  = 2'd0;
          state_next = ST_AX_INIT;
        end
      end
      ST_AX_INIT: begin
        neg_next   = s_sel[13];
        dvd_next   = db_zero ? '0 : {a_mag - {2'b0, deadband}, 12'b0};
        dsr_next   = db_zero ? 13'd1 : 13'(ONE) - {1'b0, deadband};
        rem_next   = '0;
        cnt_next   = 5'(DIV_W - 1);
        state_next = ST_AX_DIV;
      end
      ST_AX_DIV: begin
        rem_next = ge ? 13'(trial - {1'b0, dsr}) : trial[12:0];
        dvd_next = {dvd[DIV_W-2:0], ge};
        cnt_next = cnt - 5'd1;
        if (cnt == 5'd0) begin
          mcand_next  = ACC_W'({dvd[DIV_W-2:0], ge});
          mplier_next = rate_sel;
          acc_next    = '0;
          cnt_next    = 5'd13;
          state_next  = ST_AX_MUL1;
        end
      end
      ST_AX_MUL1, ST_AX_MUL2, ST_SQ1, ST_SQ2, ST_YAW: begin
        acc_next    = acc_sum;
        mcand_next  = mcand << 1;
        mplier_next = mplier >> 1;
        cnt_next    = cnt - 5'd1;
        if (cnt == 5'd0) begin
          unique case (state)
            ST_AX_MUL1: begin
              mcand_next  = acc_sum;
              mplier_next = {1'b0, dt_r};
              acc_next    = '0;
              cnt_next    = 5'd12;
              state_next  = ST_AX_MUL2;
            end
            ST_AX_MUL2: state_next = ST_AX_UPD;
            ST_SQ1: begin
              mcand_next  = ACC_W'(dz_mag);
              mplier_next = dz_mag;
              cnt_next    = 5'd13;
              state_next  = ST_SQ2;
            end
            ST_SQ2: begin
              sq_start   = 1'b1;
              state_next = ST_SQRT;
            end
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_AX_UPD: begin
        unique case (axis)
          2'd0: pose_fwd_next = (vsum < FWD_MIN) ? 16'(FWD_MIN) :
                                (vsum > FWD_MAX) ? 16'(FWD_MAX) : 16'(vsum);
          2'd1: pose_height_next = (vsum < HGT_MIN) ? 16'(HGT_MIN) :
                                   (vsum > HGT_MAX) ? 16'(HGT_MAX) : 16'(vsum);
          2'd2: pose_heading_next = 16'(vclamp);
          default: pose_tilt_next = (vsum < -TILT_LIM) ? 16'(-TILT_LIM) :
                                    (vsum > TILT_LIM) ? 16'(TILT_LIM) : 16'(vsum);
        endcase
        axis_next = axis + 2'd1;
        if (axis == 2'd3) begin
          // pose_fwd and pose_height are already final here
          mcand_next  = ACC_W'(dx_mag);
          mplier_next = dx_mag;
          acc_next    = '0;
          cnt_next    = 5'd13;
          state_next  = ST_SQ1;
        end else begin
          state_next = ST_AX_INIT;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          mcand_next  = ACC_W'(e_mag);
          mplier_next = heading_gain;
          acc_next    = '0;
          cnt_next    = 5'd13;
          state_next  = ST_YAW;
        end
      end
      ST_FIN: begin
        // output register free or being emptied this cycle
        if (!m_tvalid || m_tready) begin
          m_tdata_next  = {6'b0, yaw_v, hdg_tgt, pose_tilt[13:0], ext_fin};
          m_tuser_next  = limited;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      pose_fwd     <= 16'(2 * ONE);
      pose_height  <= 16'(ONE);
      pose_heading <= '0;
      pose_tilt    <= '0;
    end else begin
      state        <= state_next;
      m_tvalid     <= m_tvalid_next;
      pose_fwd     <= pose_fwd_next;
      pose_height  <= pose_height_next;
      pose_heading <= pose_heading_next;
      pose_tilt    <= pose_tilt_next;
    end
  end

  always_ff @(posedge clk) begin
    axis    <= axis_next;
    cnt     <= cnt_next;
    dvd     <= dvd_next;
    dsr     <= dsr_next;
    rem     <= rem_next;
    neg     <= neg_next;
    mcand   <= mcand_next;
    mplier  <= mplier_next;
    acc     <= acc_next;
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
    if (s_tvalid && s_tready) begin
      stick[0]  <= s_tdata[13:0];
      stick[1]  <= s_tdata[27:14];
      stick[2]  <= s_tdata[41:28];
      stick[3]  <= s_tdata[55:42];
      dt_r      <= s_tdata[68:56];
      chassis_r <= s_tdata[83:69];
    end
  end

  // a word taken leaves the sequencer busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  // tilt stays inside its mechanical limit
  a_tilt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[28:15]) <= 14'sd6431) &&
                 ($signed(m_tdata[28:15]) >= -14'sd6431))
    else $error("tilt out of range");

  // yaw command saturated at half a radian per second
  a_yaw: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[57:45]) <= 13'sd2048) &&
                 ($signed(m_tdata[57:45]) >= -13'sd2048))
    else $error("yaw command not saturated");

  // boom never below the minimum reach
  a_boom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[14:0] >= reach_min)
    else $error("boom below minimum reach");

endmodule

// ----- dv/joystick_bucket_pose_integrator_core_tb.sv -----
// self-checking testbench for the joystick bucket pose integrator core
// drives stick words and register writes, predicts every result in the bench, compares by field
// depends on jbpi_pkg and the core rtl
module joystick_bucket_pose_integrator_core_tb;
  import jbpi_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [87:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  always #1 clk = ~clk;

  joystick_bucket_pose_integrator_core i_dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // one expected output word: the fields the block packs, plus the reach-limited flag
  typedef struct packed {
    logic [14:0] boom;
    logic [13:0] tilt;
    logic [15:0] heading;
    logic [12:0] yaw;
    logic        limited;
  } pose_out_t;

  pose_out_t pending_out[$];

  // bench copy of the registers and the stored pose
  longint db_r, spd_x, spd_z, rate_hd, rate_tl, gain_hd, rch_min, rch_max;
  longint p_fwd, p_hgt, p_hd, p_tl;

  int  n_words, n_results, n_mismatch, n_limited, n_cfg;
  bit  quiet_tail;   // no idling on either side near the end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint shape_stick(longint s);
    longint a, r;
    a = (s < 0) ? -s : s;
    if (db_r >= ONE || a < db_r) return 0;
    r = ((a - db_r) <<< FRAC_BITS) / (ONE - db_r);
    return (s > 0) ? r : -r;
  endfunction

  function automatic longint pose_step(longint r, longint rate, longint dt);
    longint m, d;
    m = (r < 0) ? -r : r;
    d = (m * rate * dt) >>> (2 * FRAC_BITS);
    return (r < 0) ? -d : d;
  endfunction

  function automatic longint wrap_pi(longint v);
    if (v >= PI_Q) return v - 2 * PI_Q;
    if (v < -PI_Q) return v + 2 * PI_Q;
    return v;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 40;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // advance the bench pose by one tick and return the result it should produce
  function automatic pose_out_t integrate_tick(logic [87:0] w);
    pose_out_t o;
    longint dt, ch, dx, ext, e, ym, yw;
    dt = w[68:56];
    ch = $signed(w[83:69]);
    p_fwd = clip(p_fwd + pose_step(shape_stick($signed(w[13:0])), spd_x, dt), FWD_MIN, FWD_MAX);
    p_hgt = clip(p_hgt + pose_step(shape_stick($signed(w[27:14])), spd_z, dt), HGT_MIN, HGT_MAX);
    p_hd  = clip(wrap_pi(p_hd + pose_step(shape_stick($signed(w[41:28])), rate_hd, dt)),
                 -PI_Q, PI_Q);
    p_tl  = clip(p_tl + pose_step(shape_stick($signed(w[55:42])), rate_tl, dt),
                 -TILT_LIM, TILT_LIM);
    dx = p_fwd - BOOM_BASE;
    ext = root_floor(dx * dx + p_hgt * p_hgt);
    o.limited = 1'b0;
    if (ext > rch_max) begin
      ext = rch_max;
      o.limited = 1'b1;
    end
    if (ext < rch_min) ext = rch_min;
    e = wrap_pi(p_hd);
    ym = (((e < 0) ? -e : e) * gain_hd) >>> FRAC_BITS;
    yw = clip((e < 0) ? -ym : ym, -YAW_LIM, YAW_LIM);
    o.boom    = ext[14:0];
    o.tilt    = p_tl[13:0];
    o.heading = 16'(ch + p_hd);
    o.yaw     = yw[12:0];
    return o;
  endfunction

  // valid drops only while the sender idles
  task automatic idle_burst();
    if (!quiet_tail && $urandom_range(3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  endtask

  // send one stick word and record the predicted result at acceptance
  task automatic send_tick(int fwd, int hgt, int hd, int tl, int dt, int ch);
    logic [87:0] w;
    idle_burst();
    w = '0;
    w[13:0] = fwd[13:0];
    w[27:14] = hgt[13:0];
    w[41:28] = hd[13:0];
    w[55:42] = tl[13:0];
    w[68:56] = dt[12:0];
    w[83:69] = ch[14:0];
    s_tdata <= w;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_out.push_back(integrate_tick(w));
    n_words++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // register write, only with the core idle
  task automatic write_reg(reg_idx_t idx, int val);
    cfg_index <= idx;
    cfg_data <= val[14:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_cfg++;
    case (idx)
      REG_DEADBAND:     db_r    = val & 12'hFFF;
      REG_SPEED_X:      spd_x   = val & 14'h3FFF;
      REG_SPEED_Z:      spd_z   = val & 14'h3FFF;
      REG_RATE_HEADING: rate_hd = val & 14'h3FFF;
      REG_RATE_TILT:    rate_tl = val & 14'h3FFF;
      REG_HEADING_GAIN: gain_hd = val & 14'h3FFF;
      REG_REACH_MIN:    rch_min = val & 15'h7FFF;
      default:          rch_max = val & 15'h7FFF;
    endcase
  endtask

  function automatic int rnd_stick();
    return $urandom_range(8192) - 4096;
  endfunction

  function automatic int rnd_heading();
    return $urandom_range(25736) - 12868;
  endfunction

  task automatic send_random(int n);
    repeat (n)
      send_tick(rnd_stick(), rnd_stick(), rnd_stick(), rnd_stick(),
                ($urandom_range(3) == 0) ? $urandom_range(4096) : $urandom_range(400),
                rnd_heading());
  endtask

  // sticks at the extremes, at and around the deadband, zero and full time steps
  task automatic test_directed();
    send_tick(0, 0, 0, 0, 0, 0);
    send_tick(4096, 4096, 4096, 4096, 4096, 12868);
    send_tick(4096, 4096, 4096, 4096, 4096, -12868);
    send_tick(-4096, -4096, -4096, -4096, 4096, 0);
    send_tick(-4096, -4096, -4096, -4096, 4096, -1);
    send_tick(204, -204, 205, -205, 4096, 1);
    send_tick(206, -206, 4095, -4095, 4096, 12867);
    send_tick(8191, -8192, 8191, -8192, 8191, 16383);
    send_tick(-8192, 8191, -8192, 8191, 8191, -16384);
    send_tick(4096, 0, 4096, 0, 4096, 100);
    send_tick(-4096, 0, -4096, 0, 4096, -100);
    send_tick(0, 4096, 0, 4096, 4096, 0);
  endtask

  // deadband written as one (truncated to zero) and just below one, zero and full rates, reach minimum above maximum
  task automatic test_config_extremes();
    drain();
    write_reg(REG_DEADBAND, 4096);
    send_tick(4096, -4096, 4096, -4096, 4096, 0);
    drain();
    write_reg(REG_DEADBAND, 4095);
    write_reg(REG_REACH_MIN, 32767);
    write_reg(REG_REACH_MAX, 0);
    send_random(8);
    drain();
    write_reg(REG_DEADBAND, 0);
    write_reg(REG_SPEED_X, 0);
    write_reg(REG_SPEED_Z, 0);
    write_reg(REG_RATE_HEADING, 0);
    write_reg(REG_RATE_TILT, 0);
    write_reg(REG_HEADING_GAIN, 0);
    write_reg(REG_REACH_MIN, 0);
    write_reg(REG_REACH_MAX, 32767);
    send_random(8);
    drain();
    write_reg(REG_SPEED_X, 16383);
    write_reg(REG_SPEED_Z, 16383);
    write_reg(REG_RATE_HEADING, 16383);
    write_reg(REG_RATE_TILT, 16383);
    write_reg(REG_HEADING_GAIN, 16383);
    write_reg(REG_DEADBAND, 2048);
    send_random(20);
  endtask

  // random words over several register settings
  task automatic test_random_sweep();
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(REG_DEADBAND, $urandom_range(4095));
      write_reg(REG_SPEED_X, $urandom_range(16383));
      write_reg(REG_SPEED_Z, $urandom_range(16383));
      write_reg(REG_RATE_HEADING, $urandom_range(16383));
      write_reg(REG_RATE_TILT, $urandom_range(16383));
      write_reg(REG_HEADING_GAIN, $urandom_range(16383));
      write_reg(REG_REACH_MIN, $urandom_range(ph == 3 ? 32767 : 8192));
      write_reg(REG_REACH_MAX, $urandom_range(4096, 32767));
      send_random(100);
    end
    drain();
    write_reg(REG_DEADBAND, 205);
    write_reg(REG_REACH_MIN, 2048);
    write_reg(REG_REACH_MAX, 12288);
    quiet_tail = 1'b1;
    send_random(60);
  endtask

  // result side: random stalls, each word checked against the oldest prediction
  always @(posedge clk) begin
    if (rst || quiet_tail) m_tready <= 1'b1;
    else if ($urandom_range(7) == 0) m_tready <= 1'b0;
    else if ($urandom_range(3) == 0) m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    pose_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.boom = m_tdata[14:0];
      got.tilt = m_tdata[28:15];
      got.heading = m_tdata[44:29];
      got.yaw = m_tdata[57:45];
      got.limited = m_tuser;
      n_results++;
      if (got.limited) n_limited++;
      if (pending_out.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result word %h", m_tdata);
      end else begin
        want = pending_out.pop_front();
        if (got != want || m_tdata[63:58] != '0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: boom %0d/%0d tilt %0d/%0d hdg %0d/%0d yaw %0d/%0d lim %0d/%0d",
                     want.boom, got.boom, $signed(want.tilt), $signed(got.tilt),
                     $signed(want.heading), $signed(got.heading), $signed(want.yaw),
                     $signed(got.yaw), want.limited, got.limited);
        end
      end
    end
  end

  initial begin
    db_r = 205; spd_x = 2048; spd_z = 1229; rate_hd = 1229; rate_tl = 2048;
    gain_hd = 2048; rch_min = 2048; rch_max = 12288;
    p_fwd = 2 * ONE; p_hgt = ONE; p_hd = 0; p_tl = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_sweep();
    drain();
    $display("%0d stick words, %0d results (%0d reach limited), %0d register writes",
             n_words, n_results, n_limited, n_cfg);
    if (n_mismatch == 0 && pending_out.size() == 0)
      $display("joystick_bucket_pose_integrator_core_tb passed");
    else
      $display("joystick_bucket_pose_integrator_core_tb failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("joystick_bucket_pose_integrator_core_tb failed");
    $finish;
  end

endmodule
